// ===== rtl/u2c_pkg.sv =====
// ----------------------------------------------------------------------------
// u2c_pkg
// shared types, constants and decode tables for the utf-8 to cp1252 converter
// ----------------------------------------------------------------------------
package u2c_pkg;

    // dfa states
    localparam logic [3:0] ST_ACCEPT  = 4'd0;
    localparam logic [3:0] ST_REJECT  = 4'd1;
    localparam logic [3:0] NUM_STATES = 4'd9;

    // byte classes
    localparam logic [3:0] CLS_ASCII    = 4'd0;   // 00..7f
    localparam logic [3:0] CLS_CONT_LO  = 4'd1;   // 80..8f
    localparam logic [3:0] CLS_LEAD2    = 4'd2;   // c2..df
    localparam logic [3:0] CLS_LEAD3    = 4'd3;   // e1..ec, ee..ef
    localparam logic [3:0] CLS_ED       = 4'd4;   // ed
    localparam logic [3:0] CLS_F4       = 4'd5;   // f4
    localparam logic [3:0] CLS_LEAD4    = 4'd6;   // f1..f3
    localparam logic [3:0] CLS_CONT_HI  = 4'd7;   // a0..bf
    localparam logic [3:0] CLS_INVALID  = 4'd8;   // c0, c1, f5..ff
    localparam logic [3:0] CLS_CONT_MID = 4'd9;   // 90..9f
    localparam logic [3:0] CLS_E0       = 4'd10;  // e0
    localparam logic [3:0] CLS_F0       = 4'd11;  // f0

    localparam int CP_W   = 21;
    localparam int CP16_W = 16;

    // queue between front and back, depth must be a power of two
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // next state by [state][class]
    localparam logic [3:0] DFA_NEXT [0:8][0:15] = '{
        '{4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1}
    };

    // code point that lands on cp1252 byte 80+i, zero marks an undefined slot
    localparam logic [15:0] CP1252_HIGH [0:31] = '{
        16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
        16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
    };

    // completed character handed from front to queue
    typedef struct packed {
        logic              valid;
        logic [CP16_W-1:0] cp16;
    } cp_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    function automatic logic [3:0] byte_class(input logic [7:0] b);
        logic [3:0] c;
        if (b < 8'h80)       c = CLS_ASCII;
        else if (b < 8'h90)  c = CLS_CONT_LO;
        else if (b < 8'hA0)  c = CLS_CONT_MID;
        else if (b < 8'hC0)  c = CLS_CONT_HI;
        else if (b < 8'hC2)  c = CLS_INVALID;
        else if (b < 8'hE0)  c = CLS_LEAD2;
        else if (b == 8'hE0) c = CLS_E0;
        else if (b == 8'hED) c = CLS_ED;
        else if (b < 8'hF0)  c = CLS_LEAD3;
        else if (b == 8'hF0) c = CLS_F0;
        else if (b < 8'hF4)  c = CLS_LEAD4;
        else if (b == 8'hF4) c = CLS_F4;
        else                 c = CLS_INVALID;
        return c;
    endfunction

    function automatic logic [7:0] map_cp1252(input logic [CP16_W-1:0] cp);
        logic [7:0] r;
        r = 8'h00;
        if (cp <= 16'h00FF)
        begin
            r = cp[7:0];
        end
        else
        begin
            for (int i = 0; i < 32; i++)
            begin
                if (CP1252_HIGH[i] != 16'h0000 && CP1252_HIGH[i] == cp)
                begin
                    r = 8'h80 | 8'(i);
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/u2c_front.sv =====
// ----------------------------------------------------------------------------
// u2c_front
// classifies each input byte, steps the dfa and gathers the code point
// ----------------------------------------------------------------------------
module u2c_front
    import u2c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       string_start,
    output cp_item_t   wr_item,
    output logic [3:0] dfa_state
);

    logic [3:0]      state_reg, state_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic [3:0]      st_eff;
    logic [CP_W-1:0] cp_eff;
    logic [3:0]      cls;
    logic [7:0]      lead_mask;

    always_comb
    begin
        st_eff = string_start ? ST_ACCEPT : state_reg;
        cp_eff = string_start ? '0 : cp_reg;
        if (st_eff >= NUM_STATES)
        begin
            st_eff = ST_REJECT;
        end
        cls       = byte_class(in_byte);
        lead_mask = 8'hFF >> cls;
        if (st_eff != ST_ACCEPT)
        begin
            cp_next = {cp_eff[CP_W-7:0], in_byte[5:0]};
        end
        else
        begin
            cp_next = {{(CP_W-8){1'b0}}, lead_mask & in_byte};
        end
        state_next = DFA_NEXT[st_eff][cls];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
            cp_reg    <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            cp_reg    <= cp_next;
        end
    end

    assign wr_item.valid = accept && (state_next == ST_ACCEPT);
    assign wr_item.cp16  = cp_next[CP16_W-1:0];
    assign dfa_state     = state_reg;

endmodule

// ===== rtl/u2c_fifo.sv =====
// ----------------------------------------------------------------------------
// u2c_fifo
// short queue of completed code points between front and back
// ----------------------------------------------------------------------------
module u2c_fifo
    import u2c_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cp_item_t          wr_item,
    input  logic              rd,
    output logic [CP16_W-1:0] head,
    output fifo_status_t      status
);

    logic [CP16_W-1:0]     mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic                  do_wr, do_rd;

    assign status.full  = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_wr        = wr_item.valid && !status.full;
    assign do_rd        = rd && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item.cp16;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/u2c_back.sv =====
// ----------------------------------------------------------------------------
// u2c_back
// maps queued code points to cp1252 and holds the result in an output register
// ----------------------------------------------------------------------------
module u2c_back
    import u2c_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CP16_W-1:0] head,
    input  fifo_status_t      status,
    output logic              rd,
    input  logic              pop,
    output logic              empty,
    output logic [7:0]        out_byte
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign rd       = !status.empty && (!out_valid_reg || pop);

    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            out_byte_reg <= map_cp1252(head);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rd)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/utf8_to_cp1252_converter.sv =====
// ----------------------------------------------------------------------------
// utf8_to_cp1252_converter
// streaming utf-8 decoder with windows-1252 output mapping
// ----------------------------------------------------------------------------
// Push one utf-8 byte per cycle while full is low; string_start on a byte
// clears the decoder to the accept state before that byte is decoded. Each
// byte that completes a character yields one cp1252 byte on out_byte (code
// points up to 0xff pass through, the defined 0x80..0x9f specials map there,
// anything else gives 0x00; only the low 16 bits of the code point count).
// Lead bytes, non-final continuation bytes and every byte after an invalid
// sequence give nothing until the next string_start. A byte enters the dfa
// in the cycle it is pushed; its result passes the queue write and then the
// output register before it shows on out_byte. Sustained rate is one byte
// per cycle while full is low, as the front steps the dfa on each taken byte.
// A four-entry queue decouples decode from the output register, so full only
// rises once four completed characters wait behind an unpopped result.
// ----------------------------------------------------------------------------
module utf8_to_cp1252_converter
    import u2c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input item
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       string_start,
    // result item
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte
);

    cp_item_t          wr_item;
    fifo_status_t      fifo_status;
    logic [CP16_W-1:0] fifo_head;
    logic              fifo_rd;
    logic [3:0]        dfa_state;
    logic              in_accept;

    // a byte is taken whenever the queue can hold a possible result
    assign full      = fifo_status.full;
    assign in_accept = push && !full;

    // front: classify, step dfa, gather code point
    u2c_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .in_byte      (in_byte),
        .string_start (string_start),
        .wr_item      (wr_item),
        .dfa_state    (dfa_state)
    );

    // queue of completed 16-bit code points
    u2c_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_item (wr_item),
        .rd      (fifo_rd),
        .head    (fifo_head),
        .status  (fifo_status)
    );

    // back: map and register the output item
    u2c_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (fifo_head),
        .status   (fifo_status),
        .rd       (fifo_rd),
        .pop      (pop),
        .empty    (empty),
        .out_byte (out_byte)
    );

    // the queue is never written while it is full
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_item.valid |-> !fifo_status.full)
        else $error("character written into a full queue");

    // the dfa never leaves its nine defined states
    assert property (@(posedge clk) disable iff (!rst_n)
        dfa_state < NUM_STATES)
        else $error("dfa in an undefined state");

    // an ascii byte decoded from the accept state always completes a character
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !in_byte[7] && (string_start || dfa_state == ST_ACCEPT))
        |-> wr_item.valid)
        else $error("ascii byte lost in accept state");

    // the back only reads a queue that holds something
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_status.empty |-> !fifo_rd)
        else $error("read from an empty queue");

endmodule
